// ----- rtl/core/irans_pkg.sv -----
// Shared constants and types of the interleaved rANS encoder.
package irans_pkg;

	localparam int LANES       = 32;
	localparam int PROB_BITS   = 12;
	localparam int RENORM_BITS = 16;
	localparam int SYMBOLS     = 256;
	localparam int MAXOUT      = 32;

	localparam int FUNC_W  = 2;
	localparam int SYM_W   = 8;
	localparam int LANE_W  = 5;
	localparam int FREQ_W  = 13;
	localparam int START_W = 12;
	localparam int ENTRY_W = FREQ_W + START_W;
	localparam int KIND_W  = 2;
	localparam int STATE_W = 32;
	localparam int POS_W   = 6;
	localparam int OUTN_W  = $clog2(MAXOUT);
	localparam int STEP_W  = $clog2(STATE_W);
	localparam int HALF    = LANES / 2;

	// Threshold is ((L >> PROB_BITS) << RENORM_BITS) * freq with L = 2^RENORM_BITS.
	localparam int THR_SH  = 2 * RENORM_BITS - PROB_BITS;
	localparam int THR_W   = FREQ_W + THR_SH;

	localparam logic [STATE_W-1:0] LANE_INIT = STATE_W'(1) << RENORM_BITS;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ENC   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd3;

	localparam logic [KIND_W-1:0] KIND_WORD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STATE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERR   = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOOK  = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_FIN   = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

endpackage

// ----- rtl/core/interleaved_rans_encoder.sv -----
// Interleaved rANS encoder: sequencer, shared radix-2 divider, lane states and symbol table.
//
// Input channel (in_valid/in_ready) carries one command per transaction: func selects a
// symbol table write (symbol, sym_freq, sym_start), a reset of all lane states to 2^16,
// an encode of symbol on lane, or a flush of the lane states.
// Output channel (out_valid/out_ready) carries kind, value, stream and last; last marks the
// final result of a command.
// A table write or lane reset completes in the cycle it is accepted. An encode holds
// in_ready low through one table read, one renormalize check, 32 steps of the shared
// radix-2 divider (32-bit state by 13-bit frequency) and the new lane state's write-back.
// A flush emits every lane state, 32 with 32 lanes, one per cycle while not stalled.
// A renormalization word or an error is emitted in the check cycle.
// When the receiver stalls, the sequencer holds in the cycle that wants to emit until the
// output register is free; the output register lets the next command start while a
// result still waits.
// Reset clears the sequencer, empties the output register and sets every lane state to
// 2^16. The symbol table has no reset: encoding a symbol never written gives any result.
module interleaved_rans_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [irans_pkg::FUNC_W-1:0]  func,
	input  logic [irans_pkg::SYM_W-1:0]   symbol,
	input  logic [irans_pkg::LANE_W-1:0]  lane,
	input  logic [irans_pkg::FREQ_W-1:0]  sym_freq,
	input  logic [irans_pkg::START_W-1:0] sym_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [irans_pkg::KIND_W-1:0]  kind,
	output logic [irans_pkg::STATE_W-1:0] value,
	output logic                          stream,
	output logic                          last
);
	import irans_pkg::*;

	state_t state_q;

	logic [ENTRY_W-1:0] table_mem [SYMBOLS];
	logic [ENTRY_W-1:0] entry_q;
	logic [STATE_W-1:0] lanes_q [LANES];

	logic [SYM_W-1:0]   symbol_q;
	logic [LANE_W-1:0]  lane_q;
	logic [STATE_W-1:0] dq_q;
	logic [FREQ_W-1:0]  rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [POS_W-1:0]   flush_idx_q;
	logic [POS_W-1:0]   pos_q;
	logic [OUTN_W-1:0]  outn_q;

	logic               out_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [STATE_W-1:0] value_q;
	logic               stream_q;
	logic               last_q;

	logic                in_acc;
	logic                slot_free;
	logic [FREQ_W-1:0]   freq;
	logic [START_W-1:0]  start;
	logic [LANE_W-1:0]   flush_lane;
	logic [LANE_W-1:0]   rd_lane;
	logic [STATE_W-1:0]  rd_state;
	logic [THR_W-1:0]    thr;
	logic                renorm;
	logic                flush_last;
	logic [POS_W-1:0]    pos_next;
	logic [FREQ_W:0]     rem_sh;
	logic                ge;
	logic [FREQ_W-1:0]   rem_d;
	logic [STATE_W-1:0]  new_state;

	logic                emit_req;
	logic [KIND_W-1:0]   emit_kind;
	logic [STATE_W-1:0]  emit_value;
	logic                emit_stream;
	logic                emit_last;
	logic                go;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// A symbol outside the table reads as zero frequency.
	assign freq  = ({1'b0, symbol_q} < (SYM_W + 1)'(SYMBOLS)) ? entry_q[FREQ_W-1:0] : '0;
	assign start = entry_q[ENTRY_W-1:FREQ_W];

	// Flush walks the forward lanes downwards, then the reverse lanes upwards.
	assign flush_lane = (pos_q < POS_W'(HALF)) ? LANE_W'(POS_W'(HALF - 1) - pos_q)
	                                           : LANE_W'(pos_q);
	assign rd_lane    = (state_q == ST_FLUSH) ? flush_lane : lane_q;
	assign rd_state   = lanes_q[rd_lane];

	assign thr    = {freq, {THR_SH{1'b0}}};
	assign renorm = (THR_W'(rd_state) >= thr);

	assign flush_last = (pos_q == POS_W'(LANES - 1)) || (outn_q == OUTN_W'(MAXOUT - 1));
	assign pos_next   = (pos_q == POS_W'(LANES - 1)) ? '0 : pos_q + POS_W'(1);

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	assign rem_sh = {rem_q, dq_q[STATE_W-1]};
	assign ge     = (rem_sh >= {1'b0, freq});
	assign rem_d  = ge ? FREQ_W'(rem_sh - {1'b0, freq}) : rem_sh[FREQ_W-1:0];

	assign new_state = (dq_q << PROB_BITS) + STATE_W'(rem_q) + STATE_W'(start);

	always_comb begin
		emit_req    = 1'b0;
		emit_kind   = KIND_WORD;
		emit_value  = '0;
		emit_stream = (lane_q >= LANE_W'(HALF));
		emit_last   = 1'b1;
		unique case (state_q)
			ST_LOOK: begin
				if (freq == '0) begin
					emit_req  = 1'b1;
					emit_kind = KIND_ERR;
				end else if (renorm) begin
					emit_req   = 1'b1;
					emit_value = STATE_W'(rd_state[RENORM_BITS-1:0]);
				end
			end
			ST_FLUSH: begin
				emit_req    = 1'b1;
				emit_kind   = KIND_STATE;
				emit_value  = rd_state;
				emit_stream = (flush_lane >= LANE_W'(HALF));
				emit_last   = flush_last;
			end
			default: begin
			end
		endcase
	end

	assign go = !emit_req || slot_free;

	// Symbol table: written on a table write, read once per encode command.
	always_ff @(posedge clk) begin
		if (in_acc && func == FUNC_WRITE && {1'b0, symbol} < (SYM_W + 1)'(SYMBOLS)) begin
			table_mem[symbol] <= {sym_start, sym_freq};
		end
		if (in_acc && func == FUNC_ENC) begin
			entry_q <= table_mem[symbol];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				lanes_q[i] <= LANE_INIT;
			end
		end else if (in_acc && func == FUNC_RESET) begin
			for (int i = 0; i < LANES; i++) begin
				lanes_q[i] <= LANE_INIT;
			end
		end else if (state_q == ST_FIN) begin
			lanes_q[lane_q] <= new_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flush_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (func)
							FUNC_RESET: flush_idx_q <= '0;
							FUNC_ENC:   state_q <= ST_LOOK;
							FUNC_FLUSH: state_q <= ST_FLUSH;
							default: begin
							end
						endcase
					end
				end
				ST_LOOK: begin
					if (go) begin
						state_q <= (freq == '0) ? ST_IDLE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(STATE_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					if (go && flush_last) begin
						state_q     <= ST_IDLE;
						flush_idx_q <= pos_next;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of the sequencer and divider.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			symbol_q <= symbol;
			lane_q   <= lane;
			pos_q    <= (flush_idx_q >= POS_W'(LANES)) ? '0 : flush_idx_q;
			outn_q   <= '0;
		end
		if (state_q == ST_LOOK) begin
			dq_q   <= renorm ? (rd_state >> RENORM_BITS) : rd_state;
			rem_q  <= '0;
			step_q <= '0;
		end
		if (state_q == ST_DIV) begin
			dq_q   <= {dq_q[STATE_W-2:0], ge};
			rem_q  <= rem_d;
			step_q <= step_q + STEP_W'(1);
		end
		if (state_q == ST_FLUSH && go) begin
			pos_q  <= pos_next;
			outn_q <= outn_q + OUTN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_req && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && slot_free) begin
			kind_q   <= emit_kind;
			value_q  <= emit_value;
			stream_q <= emit_stream;
			last_q   <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign stream    = stream_q;
	assign last      = last_q;

	// The divider remainder always stays below the divisor.
	a_rem_below_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_FIN) |-> (rem_q < freq))
		else $error("divider remainder not below frequency");

	// An error result always closes its command.
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_ERR) |-> (last_q && value_q == '0))
		else $error("error result without last or with a value");

	// The saved flush position always names a lane.
	a_flush_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		flush_idx_q < POS_W'(LANES))
		else $error("flush position out of range");

	// A finished division writes back and returns to idle in the next cycle.
	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (state_q == ST_IDLE))
		else $error("write-back did not return to idle");

endmodule
